// File: src/ps_pkg.sv
`default_nettype none

package ps_pkg;

  localparam int CHR_W = 8;
  localparam int STAR_W = 32;
  localparam int VAL_W = 31;
  localparam int LEN_W = 3;
  localparam int FLAG_W = 5;

  // Format characters
  localparam logic [CHR_W-1:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [CHR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHR_W-1:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [CHR_W-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CHR_W-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [CHR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [CHR_W-1:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [CHR_W-1:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [CHR_W-1:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [CHR_W-1:0] CH_H     = 8'h68;  // 'h'
  localparam logic [CHR_W-1:0] CH_L     = 8'h6C;  // 'l'
  localparam logic [CHR_W-1:0] CH_J     = 8'h6A;  // 'j'
  localparam logic [CHR_W-1:0] CH_Z     = 8'h7A;  // 'z'

  // Length modifier codes, ordered so the larger code wins
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_HH   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_H    = 3'd2;
  localparam logic [LEN_W-1:0] LEN_L    = 3'd3;
  localparam logic [LEN_W-1:0] LEN_LL   = 3'd4;
  localparam logic [LEN_W-1:0] LEN_J    = 3'd5;
  localparam logic [LEN_W-1:0] LEN_Z    = 3'd6;

  // Flag bit positions
  localparam int FB_ALT   = 0;
  localparam int FB_ZERO  = 1;
  localparam int FB_LEFT  = 2;
  localparam int FB_SIGN  = 3;
  localparam int FB_SPACE = 4;

  function automatic logic [LEN_W-1:0] max_len(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// File: src/ps_in_if.sv
`default_nettype none

interface ps_in_if;
  logic                            valid;
  logic                            ready;
  logic [ps_pkg::CHR_W-1:0]        character;
  logic signed [ps_pkg::STAR_W-1:0] star_value;

  modport source (output valid, output character, output star_value, input ready);
  modport sink   (input valid, input character, input star_value, output ready);
endinterface

`default_nettype wire

// File: src/ps_out_if.sv
`default_nettype none

interface ps_out_if;
  logic                     valid;
  logic                     ready;
  logic                     alternate_form;
  logic                     zero_pad;
  logic                     left_justify;
  logic                     force_sign;
  logic                     space_sign;
  logic                     width_given;
  logic [ps_pkg::VAL_W-1:0] field_width;
  logic                     precision_given;
  logic [ps_pkg::VAL_W-1:0] precision_value;
  logic [ps_pkg::LEN_W-1:0] length_code;
  logic [ps_pkg::CHR_W-1:0] conversion;

  modport source (output valid, output alternate_form, output zero_pad,
                  output left_justify, output force_sign, output space_sign,
                  output width_given, output field_width, output precision_given,
                  output precision_value, output length_code, output conversion,
                  input ready);
  modport sink   (input valid, input alternate_form, input zero_pad,
                  input left_justify, input force_sign, input space_sign,
                  input width_given, input field_width, input precision_given,
                  input precision_value, input length_code, input conversion,
                  output ready);
endinterface

`default_nettype wire

// File: src/printf_spec_parser.sv
// Path: an accepted ending character passes the input register, then the result register.
// Throughput: one character per cycle while the input stage is not stalled;
//   the parse state updates once per accepted character.
// The input stage stalls only when an ending character meets a full result register that is not being taken.
// Reset (rst_n low, synchronous) empties both registers and clears the parse state.
`default_nettype none

module printf_spec_parser #(
  parameter int COUNT_BITS = 31
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ps_in_if.sink     in_ch,
  ps_out_if.source  out_ch
);
  import ps_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Parse modes
  localparam logic [2:0] M_GENERAL = 3'd0;
  localparam logic [2:0] M_WDIGITS = 3'd1;
  localparam logic [2:0] M_DOT     = 3'd2;
  localparam logic [2:0] M_PDIGITS = 3'd3;
  localparam logic [2:0] M_PEND_H  = 3'd4;
  localparam logic [2:0] M_PEND_L  = 3'd5;

  // cnt * 10 + digit, saturating
  function automatic logic [COUNT_BITS-1:0] acc_dig(input logic [COUNT_BITS-1:0] cnt,
                                                    input logic [CHR_W-1:0] c);
    logic [COUNT_BITS+4:0] v;
    v = ({5'b0, cnt} << 3) + ({5'b0, cnt} << 1) + (COUNT_BITS+5)'(c[3:0]);
    return (|v[COUNT_BITS+4:COUNT_BITS]) ? CNT_MAX : v[COUNT_BITS-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat32(input logic [STAR_W-1:0] v);
    return (|v[STAR_W-1:COUNT_BITS]) ? CNT_MAX : v[COUNT_BITS-1:0];
  endfunction

  // Input register
  logic                  in_vld_r;
  logic [CHR_W-1:0]      chr_r;
  logic [STAR_W-1:0]     sv_r;

  // Parse state
  logic [2:0]            mode_r, mode_nxt;
  logic [FLAG_W-1:0]     flags_r, flags_nxt;
  logic                  wseen_r, wseen_nxt;
  logic [COUNT_BITS-1:0] wcnt_r, wcnt_nxt;
  logic                  pseen_r, pseen_nxt;
  logic [COUNT_BITS-1:0] pcnt_r, pcnt_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      lenpre_r, lenpre_nxt;

  // Result register
  logic                  out_vld_r;
  logic [FLAG_W-1:0]     oflags_r;
  logic                  owseen_r;
  logic [VAL_W-1:0]      owidth_r;
  logic                  opseen_r;
  logic [VAL_W-1:0]      oprec_r;
  logic [LEN_W-1:0]      olen_r;
  logic [CHR_W-1:0]      oconv_r;

  logic                  emit_c;
  logic                  handled_c;
  logic                  is_digit_c;
  logic                  star_neg_c;
  logic [STAR_W-1:0]     star_mag_c;
  logic                  out_free_c;
  logic                  stage_go_c;

  assign is_digit_c = (chr_r >= CH_ZERO) && (chr_r <= CH_NINE);
  assign star_neg_c = sv_r[STAR_W-1];
  assign star_mag_c = star_neg_c ? (~sv_r + STAR_W'(1)) : sv_r;

  // Handshake: non-ending characters always proceed
  assign out_free_c  = !out_vld_r || out_ch.ready;
  assign stage_go_c  = in_vld_r && (!emit_c || out_free_c);
  assign in_ch.ready = !in_vld_r || stage_go_c;

  // Next parse state
  always_comb begin
    mode_nxt   = mode_r;
    flags_nxt  = flags_r;
    wseen_nxt  = wseen_r;
    wcnt_nxt   = wcnt_r;
    pseen_nxt  = pseen_r;
    pcnt_nxt   = pcnt_r;
    len_nxt    = len_r;
    lenpre_nxt = lenpre_r;
    handled_c  = 1'b0;
    emit_c     = 1'b0;

    // Mode-specific continuations
    unique case (mode_r)
      M_WDIGITS: begin
        if (is_digit_c) begin
          wcnt_nxt  = acc_dig(wcnt_r, chr_r);
          handled_c = 1'b1;
        end
      end
      M_DOT: begin
        if (chr_r == CH_STAR) begin
          mode_nxt  = M_GENERAL;
          handled_c = 1'b1;
          if (star_neg_c) begin
            pseen_nxt = 1'b0;
            pcnt_nxt  = '0;
          end else begin
            pcnt_nxt = sat32(sv_r);
          end
        end else if (is_digit_c) begin
          pcnt_nxt  = acc_dig('0, chr_r);
          mode_nxt  = M_PDIGITS;
          handled_c = 1'b1;
        end
      end
      M_PDIGITS: begin
        if (is_digit_c) begin
          pcnt_nxt  = acc_dig(pcnt_r, chr_r);
          handled_c = 1'b1;
        end
      end
      M_PEND_H: begin
        if (chr_r == CH_H) begin
          len_nxt   = max_len(LEN_HH, lenpre_r);
          mode_nxt  = M_GENERAL;
          handled_c = 1'b1;
        end
      end
      M_PEND_L: begin
        if (chr_r == CH_L) begin
          len_nxt   = max_len(LEN_LL, lenpre_r);
          mode_nxt  = M_GENERAL;
          handled_c = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // General decode
    if (!handled_c) begin
      mode_nxt = M_GENERAL;
      unique case (chr_r) inside
        CH_HASH:  flags_nxt[FB_ALT]   = 1'b1;
        CH_ZERO:  flags_nxt[FB_ZERO]  = 1'b1;
        CH_MINUS: flags_nxt[FB_LEFT]  = 1'b1;
        CH_PLUS:  flags_nxt[FB_SIGN]  = 1'b1;
        CH_SPACE: flags_nxt[FB_SPACE] = 1'b1;
        [CH_ONE:CH_NINE]: begin
          wseen_nxt = 1'b1;
          wcnt_nxt  = acc_dig('0, chr_r);
          mode_nxt  = M_WDIGITS;
        end
        CH_STAR: begin
          wseen_nxt = 1'b1;
          wcnt_nxt  = sat32(star_mag_c);
          if (star_neg_c) flags_nxt[FB_LEFT] = 1'b1;
        end
        CH_DOT: begin
          pseen_nxt = 1'b1;
          pcnt_nxt  = '0;
          mode_nxt  = M_DOT;
        end
        CH_H: begin
          lenpre_nxt = len_r;
          len_nxt    = max_len(LEN_H, len_r);
          mode_nxt   = M_PEND_H;
        end
        CH_L: begin
          lenpre_nxt = len_r;
          len_nxt    = max_len(LEN_L, len_r);
          mode_nxt   = M_PEND_L;
        end
        CH_J: len_nxt = max_len(LEN_J, len_r);
        CH_Z: len_nxt = max_len(LEN_Z, len_r);
        default: begin
          // Ending character: report and start over
          emit_c     = 1'b1;
          mode_nxt   = M_GENERAL;
          flags_nxt  = '0;
          wseen_nxt  = 1'b0;
          wcnt_nxt   = '0;
          pseen_nxt  = 1'b0;
          pcnt_nxt   = '0;
          len_nxt    = LEN_NONE;
          lenpre_nxt = LEN_NONE;
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      chr_r <= in_ch.character;
      sv_r  <= in_ch.star_value;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_GENERAL;
      flags_r  <= '0;
      wseen_r  <= 1'b0;
      wcnt_r   <= '0;
      pseen_r  <= 1'b0;
      pcnt_r   <= '0;
      len_r    <= LEN_NONE;
      lenpre_r <= LEN_NONE;
    end else if (stage_go_c) begin
      mode_r   <= mode_nxt;
      flags_r  <= flags_nxt;
      wseen_r  <= wseen_nxt;
      wcnt_r   <= wcnt_nxt;
      pseen_r  <= pseen_nxt;
      pcnt_r   <= pcnt_nxt;
      len_r    <= len_nxt;
      lenpre_r <= lenpre_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stage_go_c && emit_c) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
    if (stage_go_c && emit_c) begin
      oflags_r <= flags_r;
      owseen_r <= wseen_r;
      owidth_r <= VAL_W'(wcnt_r);
      opseen_r <= pseen_r;
      oprec_r  <= VAL_W'(pcnt_r);
      olen_r   <= len_r;
      oconv_r  <= chr_r;
    end
  end

  // Flag overrides: left-justify beats zero pad, plus beats space
  assign out_ch.valid           = out_vld_r;
  assign out_ch.alternate_form  = oflags_r[FB_ALT];
  assign out_ch.zero_pad        = oflags_r[FB_ZERO] & ~oflags_r[FB_LEFT];
  assign out_ch.left_justify    = oflags_r[FB_LEFT];
  assign out_ch.force_sign      = oflags_r[FB_SIGN];
  assign out_ch.space_sign      = oflags_r[FB_SPACE] & ~oflags_r[FB_SIGN];
  assign out_ch.width_given     = owseen_r;
  assign out_ch.field_width     = owidth_r;
  assign out_ch.precision_given = opseen_r;
  assign out_ch.precision_value = oprec_r;
  assign out_ch.length_code     = olen_r;
  assign out_ch.conversion      = oconv_r;

endmodule

`default_nettype wire

// File: src/ps_checker.sv
`default_nettype none

module ps_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic                     zero_pad,
  input wire logic                     left_justify,
  input wire logic                     force_sign,
  input wire logic                     space_sign,
  input wire logic                     precision_given,
  input wire logic [ps_pkg::VAL_W-1:0] precision_value
);
  import ps_pkg::*;

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Left-justify overrides zero pad
  a_left_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(zero_pad && left_justify))
    else $error("zero pad with left-justify");

  // Plus overrides space
  a_sign_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(force_sign && space_sign))
    else $error("space sign with force sign");

  // Missing or cancelled precision reports zero
  a_prec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !precision_given |-> precision_value == '0)
    else $error("precision value without precision");

endmodule

bind printf_spec_parser ps_checker u_ps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .zero_pad        (out_ch.zero_pad),
  .left_justify    (out_ch.left_justify),
  .force_sign      (out_ch.force_sign),
  .space_sign      (out_ch.space_sign),
  .precision_given (out_ch.precision_given),
  .precision_value (out_ch.precision_value)
);

`default_nettype wire

// File: tb/tb_printf_spec_parser.sv
`timescale 1ns / 1ps

module tb_printf_spec_parser;
  import ps_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  // Parser modes of the expected-value tracker
  typedef enum logic [2:0] {
    PM_GENERAL, PM_WDIGITS, PM_DOT, PM_PDIGITS, PM_PEND_H, PM_PEND_L
  } parse_mode_t;

  typedef struct packed {
    logic              alternate_form;
    logic              zero_pad;
    logic              left_justify;
    logic              force_sign;
    logic              space_sign;
    logic              width_given;
    logic [VAL_W-1:0]  field_width;
    logic              precision_given;
    logic [VAL_W-1:0]  precision_value;
    logic [LEN_W-1:0]  length_code;
    logic [CHR_W-1:0]  conversion;
  } spec_t;

  logic clk = 1'b0;
  logic rst_n;

  ps_in_if  in_if();
  ps_out_if out_if();

  printf_spec_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #5 clk = ~clk;

  // Tracked parse state
  parse_mode_t       pm;
  logic [FLAG_W-1:0] flg;
  logic              w_seen, p_seen;
  logic [VAL_W-1:0]  w_cnt, p_cnt;
  logic [LEN_W-1:0]  len_cur, len_pre;

  spec_t spec_due[$];
  int    chars_sent;
  int    specs_checked;
  int    mismatches;
  bit    jitter_on = 1'b1;
  bit    stall_req = 1'b0;

  function automatic logic is_digit(input logic [CHR_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Decimal accumulate, saturating at the count maximum
  function automatic logic [VAL_W-1:0] acc10(input logic [VAL_W-1:0] cnt,
                                             input logic [CHR_W-1:0] c);
    logic [63:0] v;
    v = 64'(cnt) * 64'd10 + 64'(c - CH_ZERO);
    return (v > 64'(VAL_MAX)) ? VAL_MAX : v[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] clamp(input logic [STAR_W-1:0] v);
    return (v > 32'(VAL_MAX)) ? VAL_MAX : v[VAL_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] len_max(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic void clear_parse();
    pm      = PM_GENERAL;
    flg     = '0;
    w_seen  = 1'b0;
    w_cnt   = '0;
    p_seen  = 1'b0;
    p_cnt   = '0;
    len_cur = LEN_NONE;
    len_pre = LEN_NONE;
  endfunction

  // Advance the tracked state by one character; an ending character queues a spec
  task automatic parse_char(input logic [CHR_W-1:0] c, input logic [STAR_W-1:0] sv);
    logic              taken;
    logic [FLAG_W-1:0] f;
    spec_t             s;
    taken = 1'b0;
    case (pm)
      PM_WDIGITS: if (is_digit(c)) begin
        w_cnt = acc10(w_cnt, c);
        taken = 1'b1;
      end
      PM_DOT: begin
        if (c == CH_STAR) begin
          pm = PM_GENERAL;
          if (sv[STAR_W-1]) begin
            p_seen = 1'b0;
            p_cnt  = '0;
          end else begin
            p_cnt = clamp(sv);
          end
          taken = 1'b1;
        end else if (is_digit(c)) begin
          p_cnt = acc10('0, c);
          pm    = PM_PDIGITS;
          taken = 1'b1;
        end
      end
      PM_PDIGITS: if (is_digit(c)) begin
        p_cnt = acc10(p_cnt, c);
        taken = 1'b1;
      end
      PM_PEND_H: if (c == CH_H) begin
        len_cur = len_max(LEN_HH, len_pre);
        pm      = PM_GENERAL;
        taken   = 1'b1;
      end
      PM_PEND_L: if (c == CH_L) begin
        len_cur = len_max(LEN_LL, len_pre);
        pm      = PM_GENERAL;
        taken   = 1'b1;
      end
      default: ;
    endcase
    if (taken) return;

    pm = PM_GENERAL;
    if (c == CH_HASH) begin
      flg[FB_ALT] = 1'b1;
    end else if (c == CH_ZERO) begin
      flg[FB_ZERO] = 1'b1;
    end else if (c == CH_MINUS) begin
      flg[FB_LEFT] = 1'b1;
    end else if (c == CH_PLUS) begin
      flg[FB_SIGN] = 1'b1;
    end else if (c == CH_SPACE) begin
      flg[FB_SPACE] = 1'b1;
    end else if (is_digit(c)) begin
      w_seen = 1'b1;
      w_cnt  = acc10('0, c);
      pm     = PM_WDIGITS;
    end else if (c == CH_STAR) begin
      w_seen = 1'b1;
      if (sv[STAR_W-1]) begin
        flg[FB_LEFT] = 1'b1;
        w_cnt = clamp(~sv + 32'd1);
      end else begin
        w_cnt = clamp(sv);
      end
    end else if (c == CH_DOT) begin
      p_seen = 1'b1;
      p_cnt  = '0;
      pm     = PM_DOT;
    end else if (c == CH_H) begin
      len_pre = len_cur;
      len_cur = len_max(LEN_H, len_cur);
      pm      = PM_PEND_H;
    end else if (c == CH_L) begin
      len_pre = len_cur;
      len_cur = len_max(LEN_L, len_cur);
      pm      = PM_PEND_L;
    end else if (c == CH_J) begin
      len_cur = len_max(LEN_J, len_cur);
    end else if (c == CH_Z) begin
      len_cur = len_max(LEN_Z, len_cur);
    end else begin
      // Ending character: left-justify beats zero-pad, plus beats space
      f = flg;
      if (f[FB_LEFT]) f[FB_ZERO] = 1'b0;
      if (f[FB_SIGN]) f[FB_SPACE] = 1'b0;
      s.alternate_form  = f[FB_ALT];
      s.zero_pad        = f[FB_ZERO];
      s.left_justify    = f[FB_LEFT];
      s.force_sign      = f[FB_SIGN];
      s.space_sign      = f[FB_SPACE];
      s.width_given     = w_seen;
      s.field_width     = w_cnt;
      s.precision_given = p_seen;
      s.precision_value = p_cnt;
      s.length_code     = len_cur;
      s.conversion      = c;
      spec_due.push_back(s);
      clear_parse();
    end
  endtask

  function automatic string fmt_spec(input spec_t s);
    return $sformatf("flags#0-+_=%b%b%b%b%b w=%b/%0d p=%b/%0d len=%0d conv=%02h",
                     s.alternate_form, s.zero_pad, s.left_justify, s.force_sign,
                     s.space_sign, s.width_given, s.field_width, s.precision_given,
                     s.precision_value, s.length_code, s.conversion);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Input monitor and result checker
  always @(posedge clk) begin
    spec_t got, want;
    string bad;
    if (rst_n && in_if.valid && in_if.ready)
      parse_char(in_if.character, in_if.star_value);
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{alternate_form: out_if.alternate_form, zero_pad: out_if.zero_pad,
              left_justify: out_if.left_justify, force_sign: out_if.force_sign,
              space_sign: out_if.space_sign, width_given: out_if.width_given,
              field_width: out_if.field_width, precision_given: out_if.precision_given,
              precision_value: out_if.precision_value, length_code: out_if.length_code,
              conversion: out_if.conversion};
      if (spec_due.size() == 0) begin
        note_mismatch({"unexpected spec: ", fmt_spec(got)});
      end else begin
        want = spec_due.pop_front();
        bad  = "";
        if (got.alternate_form !== want.alternate_form)   bad = {bad, " alternate_form"};
        if (got.zero_pad !== want.zero_pad)               bad = {bad, " zero_pad"};
        if (got.left_justify !== want.left_justify)       bad = {bad, " left_justify"};
        if (got.force_sign !== want.force_sign)           bad = {bad, " force_sign"};
        if (got.space_sign !== want.space_sign)           bad = {bad, " space_sign"};
        if (got.width_given !== want.width_given)         bad = {bad, " width_given"};
        if (got.field_width !== want.field_width)         bad = {bad, " field_width"};
        if (got.precision_given !== want.precision_given) bad = {bad, " precision_given"};
        if (got.precision_value !== want.precision_value) bad = {bad, " precision_value"};
        if (got.length_code !== want.length_code)         bad = {bad, " length_code"};
        if (got.conversion !== want.conversion)           bad = {bad, " conversion"};
        if (bad != "")
          note_mismatch($sformatf("spec %0d differs in%s: expected %s, got %s",
                                  specs_checked, bad, fmt_spec(want), fmt_spec(got)));
        specs_checked++;
      end
    end
  end

  // Result receiver: random idling plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(jitter_on && $urandom_range(99) < 14);
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles, %0d specs outstanding",
                 quiet, spec_due.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one character; returns at the edge where it is taken
  task automatic send_char(input logic [CHR_W-1:0] c, input logic [STAR_W-1:0] sv);
    while (jitter_on && $urandom_range(99) < 14) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.character  <= c;
    in_if.star_value <= sv;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    chars_sent++;
  endtask

  // Stop offering and wait for every queued spec
  task automatic wait_results_in();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (spec_due.size() != 0);
  endtask

  function automatic logic [STAR_W-1:0] rand_star();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'(int'($urandom_range(100)) - 50);
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CHR_W-1:0] pick_flag();
    case ($urandom_range(4))
      0:       return CH_HASH;
      1:       return CH_ZERO;
      2:       return CH_MINUS;
      3:       return CH_PLUS;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [CHR_W-1:0] pick_len();
    case ($urandom_range(3))
      0:       return CH_H;
      1:       return CH_L;
      2:       return CH_J;
      default: return CH_Z;
    endcase
  endfunction

  function automatic logic [CHR_W-1:0] pick_conv();
    string s;
    s = "diouxXcspfFeEgGaAn%";
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'($urandom_range(255));
      default: return s[$urandom_range(s.len() - 1)];
    endcase
  endfunction

  function automatic logic [CHR_W-1:0] pick_noise();
    string s;
    s = "#0-+ *.hljz0123456789";
    if ($urandom_range(99) < 70) return s[$urandom_range(s.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  // Digit run; long runs push the counters into saturation
  task automatic send_digits(input bit lead_nonzero);
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(3, 1);
    for (int i = 0; i < n; i++)
      send_char(8'(CH_ZERO + ((i == 0 && lead_nonzero) ? $urandom_range(9, 1)
                                                       : $urandom_range(9))),
                $urandom());
  endtask

  task automatic send_width();
    case ($urandom_range(3))
      0:       ;
      1, 2:    send_digits(1'b1);
      default: send_char(CH_STAR, rand_star());
    endcase
  endtask

  task automatic send_precision();
    case ($urandom_range(4))
      0, 1: ;
      2:    send_char(CH_DOT, $urandom());
      3: begin
        send_char(CH_DOT, $urandom());
        send_digits(1'b0);
      end
      default: begin
        send_char(CH_DOT, $urandom());
        send_char(CH_STAR, rand_star());
      end
    endcase
  endtask

  task automatic send_length();
    case ($urandom_range(7))
      0:       ;
      1:       send_char(CH_H, $urandom());
      2:       repeat (2) send_char(CH_H, $urandom());
      3:       send_char(CH_L, $urandom());
      4:       repeat (2) send_char(CH_L, $urandom());
      5:       send_char(CH_J, $urandom());
      6:       send_char(CH_Z, $urandom());
      default: repeat ($urandom_range(3, 2)) send_char(pick_len(), $urandom());
    endcase
  endtask

  // Well-formed spec with random content; a second width now and then
  task automatic send_random_spec();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(6) : $urandom_range(3);
    repeat (n) send_char(pick_flag(), $urandom());
    repeat (($urandom_range(9) == 0) ? 2 : 1) send_width();
    send_precision();
    send_length();
    send_char(pick_conv(), $urandom());
  endtask

  task automatic send_noise();
    repeat ($urandom_range(6, 1)) send_char(pick_noise(), rand_star());
  endtask

  // Every flag but minus, most negative star width, negative star precision, hh
  task automatic test_flags_and_star();
    send_char(CH_HASH, $urandom());
    send_char(CH_ZERO, $urandom());
    send_char(CH_PLUS, $urandom());
    send_char(CH_SPACE, $urandom());
    send_char(CH_STAR, 32'h8000_0000);
    send_char(CH_DOT, $urandom());
    send_char(CH_STAR, 32'hFFFF_FFFF);
    send_char(CH_H, $urandom());
    send_char(CH_H, $urandom());
    send_char("d", $urandom());
  endtask

  // Zero flag then digits, ll, zero byte end, max star, dot alone, j and z
  task automatic test_digits_and_pairs();
    send_char(CH_ZERO, $urandom());
    send_char("4", $urandom());
    send_char(CH_ZERO, $urandom());
    send_char(CH_DOT, $urandom());
    send_char("7", $urandom());
    send_char(CH_L, $urandom());
    send_char(CH_L, $urandom());
    send_char(8'h00, $urandom());
    send_char(CH_STAR, 32'h7FFF_FFFF);
    send_char(CH_DOT, $urandom());
    send_char(CH_J, $urandom());
    send_char(CH_Z, $urandom());
    send_char(8'hFF, $urandom());
    send_char("s", $urandom());
  endtask

  task automatic test_random_mix(input int upto);
    while (chars_sent < upto) begin
      if ($urandom_range(99) < 85) send_random_spec();
      else send_noise();
    end
  endtask

  // Receiver holds off while the sender keeps offering, then a full drain
  task automatic test_output_stall();
    stall_req = 1'b1;
    repeat (25) send_random_spec();
    wait_results_in();
  endtask

  task automatic test_no_idle(input int upto);
    jitter_on = 1'b0;
    test_random_mix(upto);
    jitter_on = 1'b1;
  endtask

  initial begin
    clear_parse();
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.character  <= '0;
    in_if.star_value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_flags_and_star();
    test_digits_and_pairs();
    test_random_mix(300);
    test_output_stall();
    test_no_idle(460);
    test_random_mix(560);

    wait_results_in();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d format characters: all flags, star extremes, digit runs to saturation,",
             chars_sent);
    $display("pair modifiers, noise, a %0d-cycle output hold-off; %0d specs checked, %0d bad",
             HOLD_CYCLES, specs_checked, mismatches);
    if (mismatches == 0 && spec_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
